// ===== design/tdq_pkg.sv =====
// Package for the timer deadline queue: field widths, codes, request types
// and the delay clamp function. Depends on nothing; every other file but tdq_fifo imports it.
package tdq_pkg;

  localparam int ExpW          = 48;
  localparam int PerW          = 32;
  localparam int IdW           = 8;
  localparam int DlyW          = 16;
  localparam int DefTableDepth = 16;
  localparam int MaxFire       = 16;

  localparam logic [DlyW-1:0] MinDelayReset = 16'd100;

  localparam logic CmdAdd  = 1'b0;
  localparam logic CmdTick = 1'b1;

  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatFull = 2'd1;
  localparam logic [1:0] StatDup  = 2'd2;

  typedef struct packed {
    logic [ExpW-1:0] expiry;
    logic [IdW-1:0]  owner;
    logic [PerW-1:0] period;
  } entry_t;

  typedef struct packed {
    logic            cmd;
    logic [ExpW-1:0] expire_time;
    logic [PerW-1:0] repeat_interval;
    logic [IdW-1:0]  timer_id;
    logic [ExpW-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic            fired_valid;
    logic [IdW-1:0]  fired_id;
    logic            last_result;
    logic            next_valid;
    logic [ExpW-1:0] next_delay;
    logic            earliest_changed;
    logic [1:0]      add_status;
  } out_item_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_op_t;

  // Delay from now to an expiry, zero when already due, raised to the floor.
  function automatic logic [ExpW-1:0] clamp_delay(input logic [ExpW-1:0] when_t,
                                                  input logic [ExpW-1:0] now_t,
                                                  input logic [DlyW-1:0] floor_t);
    logic [ExpW:0]   diff;
    logic [ExpW-1:0] d;
    diff = {1'b0, when_t} - {1'b0, now_t};
    d    = (diff[ExpW] || diff[ExpW-1:0] == '0) ? '0 : diff[ExpW-1:0];
    if (d < {{(ExpW-DlyW){1'b0}}, floor_t}) begin
      d = {{(ExpW-DlyW){1'b0}}, floor_t};
    end
    return d;
  endfunction

endpackage

// ===== design/tdq_fifo.sv =====
// Two-entry request queue used at the input and between the engine and
// the result ports. Depends on nothing.
module tdq_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

// ===== design/tdq_cells.sv =====
// Sorted cell chain holding the timers in (expiry, id) order, head at cell 0.
// Depends on tdq_pkg.
module tdq_cells #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tdq_pkg::cell_op_t op,
  input  tdq_pkg::entry_t  key,
  output tdq_pkg::entry_t  head,
  output logic             head_vld,
  output logic             full,
  output logic             dup
);
  import tdq_pkg::*;

  entry_t           cell_r [DEPTH];
  entry_t           cell_nxt [DEPTH];
  entry_t           prv [DEPTH];
  entry_t           aft [DEPTH];
  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic [DEPTH-1:0] lt, lt_sh, hit;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i]  = !vld_r[i] || ({key.expiry, key.owner} < {cell_r[i].expiry, cell_r[i].owner});
      hit[i] = vld_r[i] && key.expiry == cell_r[i].expiry && key.owner == cell_r[i].owner;
    end
    lt_sh  = {lt[DEPTH-2:0], 1'b0};
    prv[0] = key;
    for (int i = 1; i < DEPTH; i++) prv[i] = cell_r[i-1];
    for (int i = 0; i < DEPTH-1; i++) aft[i] = cell_r[i+1];
    aft[DEPTH-1] = cell_r[DEPTH-1];
  end

  // Cells at and after the insertion point move one place back; the first
  // of them takes the new timer. A pop moves everything one place forward.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_nxt[i] = cell_r[i];
      if (op.ins && lt[i]) begin
        cell_nxt[i] = lt_sh[i] ? prv[i] : key;
      end else if (op.pop) begin
        cell_nxt[i] = aft[i];
      end
    end
    if (op.ins) begin
      vld_nxt = {vld_r[DEPTH-2:0], 1'b1};
    end else if (op.pop) begin
      vld_nxt = {1'b0, vld_r[DEPTH-1:1]};
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) cell_r[i] <= cell_nxt[i];
  end

  assign head     = cell_r[0];
  assign head_vld = vld_r[0];
  assign full     = vld_r[DEPTH-1];
  assign dup      = |hit;

endmodule

// ===== design/tdq_back.sv =====
// Back end sequencer: runs add and tick requests against the cell chain
// and writes result requests to the output queue. Depends on tdq_pkg.
module tdq_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [tdq_pkg::DlyW-1:0] min_delay,
  input  tdq_pkg::in_item_t        in_item,
  input  logic                     in_avail,
  output logic                     in_take,
  output tdq_pkg::cell_op_t        op,
  output tdq_pkg::entry_t          key,
  input  tdq_pkg::entry_t          head,
  input  logic                     head_vld,
  input  logic                     cell_full,
  input  logic                     cell_dup,
  output tdq_pkg::out_item_t       res,
  output logic                     res_push,
  input  logic                     res_full
);
  import tdq_pkg::*;

  localparam int CntW = $clog2(MaxFire + 1);
  localparam int IdxW = $clog2(MaxFire);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_RINS = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]      st_r, st_nxt;
  in_item_t        cur_r, cur_nxt;
  logic [CntW-1:0] n_r, n_nxt, k_r, k_nxt;
  logic [ExpW-1:0] t_r, t_nxt;
  logic [IdW-1:0]  buf_id [MaxFire];
  logic [PerW-1:0] buf_per [MaxFire];
  logic            buf_we;
  logic [IdxW-1:0] k_idx;
  logic [ExpW:0]   sum;
  logic [1:0]      stat;
  logic            last;

  assign k_idx = k_r[IdxW-1:0];
  assign sum   = {1'b0, cur_r.now_time} + {{(ExpW-PerW+1){1'b0}}, buf_per[k_idx]};

  always_comb begin
    st_nxt   = st_r;
    cur_nxt  = cur_r;
    n_nxt    = n_r;
    k_nxt    = k_r;
    t_nxt    = t_r;
    in_take  = 1'b0;
    op       = '0;
    res      = '0;
    res_push = 1'b0;
    buf_we   = 1'b0;
    stat     = StatOk;
    last     = 1'b0;
    key      = '{expiry: cur_r.expire_time, owner: cur_r.timer_id,
                 period: cur_r.repeat_interval};
    unique case (st_r)
      S_IDLE: begin
        if (in_avail) begin
          in_take = 1'b1;
          cur_nxt = in_item;
          n_nxt   = '0;
          k_nxt   = '0;
          st_nxt  = (in_item.cmd == CmdAdd) ? S_ADD : S_POP;
        end
      end
      S_ADD: begin
        if (!res_full) begin
          stat = cell_full ? StatFull : (cell_dup ? StatDup : StatOk);
          op.ins          = (stat == StatOk);
          res_push        = 1'b1;
          res.last_result = 1'b1;
          res.add_status  = stat;
          if (stat == StatOk && (!head_vld || cur_r.expire_time < head.expiry)) begin
            res.earliest_changed = 1'b1;
            res.next_valid       = 1'b1;
            res.next_delay       = clamp_delay(cur_r.expire_time, cur_r.now_time, min_delay);
          end
          st_nxt = S_IDLE;
        end
      end
      S_POP: begin
        if (n_r != CntW'(MaxFire) && head_vld && head.expiry <= cur_r.now_time) begin
          op.pop = 1'b1;
          buf_we = 1'b1;
          n_nxt  = n_r + 1'b1;
        end else begin
          st_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (k_r == n_r) begin
          k_nxt  = '0;
          st_nxt = S_EMIT;
        end else if (buf_per[k_idx] != '0) begin
          t_nxt  = sum[ExpW] ? {ExpW{1'b1}} : sum[ExpW-1:0];
          st_nxt = S_RINS;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_RINS: begin
        key    = '{expiry: t_r, owner: buf_id[k_idx], period: buf_per[k_idx]};
        op.ins = !cell_dup;
        k_nxt  = k_r + 1'b1;
        st_nxt = S_SUM;
      end
      S_EMIT: begin
        if (!res_full) begin
          last            = (n_r == '0) || (CntW'(k_r + 1'b1) == n_r);
          res_push        = 1'b1;
          res.fired_valid = (n_r != '0);
          res.fired_id    = (n_r != '0) ? buf_id[k_idx] : '0;
          res.last_result = last;
          if (last && head_vld) begin
            res.next_valid = 1'b1;
            res.next_delay = clamp_delay(head.expiry, cur_r.now_time, min_delay);
          end
          k_nxt  = k_r + 1'b1;
          st_nxt = last ? S_IDLE : S_EMIT;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    n_r   <= n_nxt;
    k_r   <= k_nxt;
    t_r   <= t_nxt;
    if (buf_we) begin
      buf_id[n_r[IdxW-1:0]]  <= head.owner;
      buf_per[n_r[IdxW-1:0]] <= head.period;
    end
  end

endmodule

// ===== design/timer_deadline_queue.sv =====
// Timer deadline queue: an add is checked and its result written in the sequencer's add state.
// A tick pops each fired timer, then re-arms each repeating one in a second pass, then
// writes its results one by one; the sequencer runs each of these steps.
// One request is worked on at a time; two-entry queues decouple both sides.
// Synchronous active-low reset empties the table and queues, min_delay 100.
module timer_deadline_queue #(
  parameter int TABLE_DEPTH = tdq_pkg::DefTableDepth
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic                     in_cmd,
  input  logic [tdq_pkg::ExpW-1:0] in_expire_time,
  input  logic [tdq_pkg::PerW-1:0] in_repeat_interval,
  input  logic [tdq_pkg::IdW-1:0]  in_timer_id,
  input  logic [tdq_pkg::ExpW-1:0] in_now_time,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic                     out_fired_valid,
  output logic [tdq_pkg::IdW-1:0]  out_fired_id,
  output logic                     out_last_result,
  output logic                     out_next_valid,
  output logic [tdq_pkg::ExpW-1:0] out_next_delay,
  output logic                     out_earliest_changed,
  output logic [1:0]               out_add_status,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [tdq_pkg::DlyW-1:0] cfg_data
);
  import tdq_pkg::*;

  logic [DlyW-1:0] min_delay_r;
  in_item_t        in_w, in_q;
  logic            in_empty, in_take;
  out_item_t       res, out_q;
  logic            res_push, res_full;
  cell_op_t        op;
  entry_t          key, head;
  logic            head_vld, cell_full, cell_dup;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_delay_r <= MinDelayReset;
    end else if (cfg_valid && cfg_ready) begin
      min_delay_r <= cfg_data;
    end
  end

  assign in_w = '{cmd: in_cmd, expire_time: in_expire_time,
                  repeat_interval: in_repeat_interval, timer_id: in_timer_id,
                  now_time: in_now_time};

  tdq_fifo #(.W($bits(in_item_t))) u_in_q (
    .clk(clk), .rst_n(rst_n),
    .push(in_push), .wdata(in_w), .full(in_full),
    .pop(in_take), .rdata(in_q), .empty(in_empty)
  );

  tdq_cells #(.DEPTH(TABLE_DEPTH)) u_cells (
    .clk(clk), .rst_n(rst_n), .op(op), .key(key),
    .head(head), .head_vld(head_vld), .full(cell_full), .dup(cell_dup)
  );

  tdq_back u_back (
    .clk(clk), .rst_n(rst_n), .min_delay(min_delay_r),
    .in_item(in_q), .in_avail(!in_empty), .in_take(in_take),
    .op(op), .key(key), .head(head), .head_vld(head_vld),
    .cell_full(cell_full), .cell_dup(cell_dup),
    .res(res), .res_push(res_push), .res_full(res_full)
  );

  tdq_fifo #(.W($bits(out_item_t))) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(res_push), .wdata(res), .full(res_full),
    .pop(out_pop), .rdata(out_q), .empty(out_empty)
  );

  assign out_fired_valid      = out_q.fired_valid;
  assign out_fired_id         = out_q.fired_id;
  assign out_last_result      = out_q.last_result;
  assign out_next_valid       = out_q.next_valid;
  assign out_next_delay       = out_q.next_delay;
  assign out_earliest_changed = out_q.earliest_changed;
  assign out_add_status       = out_q.add_status;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_reject_plain: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_add_status != StatOk) |-> (!out_next_valid && out_last_result
      && !out_fired_valid && !out_earliest_changed))
    else $error("rejected add carries more than its status");

  a_next_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_next_valid) |-> out_last_result)
    else $error("next delay reported before the last result");

endmodule

// ===== bench/timer_deadline_queue_tb.sv =====
// Self-checking testbench for timer_deadline_queue: a queue-fed driver, a monitor
// and a timer-table predictor. Depends on tdq_pkg and the timer_deadline_queue RTL.
`timescale 1ns / 1ps

module timer_deadline_queue_tb;
  import tdq_pkg::*;

  localparam int Depth = 16;
  localparam logic [ExpW-1:0] ExpMax = {ExpW{1'b1}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_cmd = 1'b0;
  logic [ExpW-1:0] in_expire_time = '0;
  logic [PerW-1:0] in_repeat_interval = '0;
  logic [IdW-1:0] in_timer_id = '0;
  logic [ExpW-1:0] in_now_time = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_fired_valid;
  logic [IdW-1:0] out_fired_id;
  logic out_last_result;
  logic out_next_valid;
  logic [ExpW-1:0] out_next_delay;
  logic out_earliest_changed;
  logic [1:0] out_add_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [DlyW-1:0] cfg_data = '0;

  timer_deadline_queue dut (.*);

  // Predicted copy of the timer table and the delay floor.
  logic tbl_used [Depth];
  logic [ExpW-1:0] tbl_expiry [Depth];
  logic [PerW-1:0] tbl_period [Depth];
  logic [IdW-1:0] tbl_owner [Depth];
  logic [DlyW-1:0] delay_floor;

  in_item_t pending_requests[$];
  out_item_t expected_results[$];
  in_item_t cur_request;
  int errors = 0;
  bit quiet = 1'b0;
  logic rx_hold = 1'b0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic [ExpW-1:0] due_in(input logic [ExpW-1:0] when_t,
                                             input logic [ExpW-1:0] now_t);
    logic [ExpW-1:0] d;
    d = (when_t > now_t) ? when_t - now_t : '0;
    if (d < ExpW'(delay_floor)) begin
      d = ExpW'(delay_floor);
    end
    return d;
  endfunction

  function automatic int soonest_slot();
    int best;
    best = -1;
    for (int i = 0; i < Depth; i++) begin
      if (tbl_used[i] && (best < 0 || tbl_expiry[i] < tbl_expiry[best] ||
          (tbl_expiry[i] == tbl_expiry[best] && tbl_owner[i] < tbl_owner[best]))) begin
        best = i;
      end
    end
    return best;
  endfunction

  function automatic logic [1:0] insert_timer(input logic [ExpW-1:0] when_t,
                                              input logic [PerW-1:0] per,
                                              input logic [IdW-1:0] id);
    int free_slot;
    free_slot = -1;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (!tbl_used[i]) free_slot = i;
    end
    if (free_slot < 0) return StatFull;
    for (int i = 0; i < Depth; i++) begin
      if (tbl_used[i] && tbl_expiry[i] == when_t && tbl_owner[i] == id) return StatDup;
    end
    tbl_used[free_slot] = 1'b1;
    tbl_expiry[free_slot] = when_t;
    tbl_period[free_slot] = per;
    tbl_owner[free_slot] = id;
    return StatOk;
  endfunction

  // Works out the results of one accepted request and queues them.
  task automatic predict_timer_results(input in_item_t rq);
    out_item_t r;
    out_item_t fired[$];
    logic [PerW-1:0] periods[$];
    logic [ExpW:0] sum;
    logic [1:0] st;
    int s;
    bit soonest;
    r = '0;
    if (rq.cmd == CmdAdd) begin
      s = soonest_slot();
      soonest = (s < 0) || (rq.expire_time < tbl_expiry[s]);
      st = insert_timer(rq.expire_time, rq.repeat_interval, rq.timer_id);
      r.last_result = 1'b1;
      r.add_status = st;
      if (st == StatOk && soonest) begin
        r.next_valid = 1'b1;
        r.next_delay = due_in(rq.expire_time, rq.now_time);
        r.earliest_changed = 1'b1;
      end
      expected_results.push_back(r);
    end else begin
      while (fired.size() < MaxFire) begin
        s = soonest_slot();
        if (s < 0 || tbl_expiry[s] > rq.now_time) break;
        r = '0;
        r.fired_valid = 1'b1;
        r.fired_id = tbl_owner[s];
        fired.push_back(r);
        periods.push_back(tbl_period[s]);
        tbl_used[s] = 1'b0;
      end
      foreach (fired[k]) begin
        if (periods[k] != 0) begin
          sum = {1'b0, rq.now_time} + (ExpW + 1)'(periods[k]);
          if (sum[ExpW]) sum[ExpW-1:0] = ExpMax;
          st = insert_timer(sum[ExpW-1:0], periods[k], fired[k].fired_id);
        end
      end
      if (fired.size() == 0) fired.push_back('0);
      r = fired.pop_back();
      r.last_result = 1'b1;
      s = soonest_slot();
      if (s >= 0) begin
        r.next_valid = 1'b1;
        r.next_delay = due_in(tbl_expiry[s], rq.now_time);
      end
      fired.push_back(r);
      foreach (fired[k]) expected_results.push_back(fired[k]);
    end
  endtask

  function automatic in_item_t mk(input logic cmd, input logic [ExpW-1:0] exp_t,
                                  input logic [PerW-1:0] per, input logic [IdW-1:0] id,
                                  input logic [ExpW-1:0] now_t);
    in_item_t it;
    it.cmd = cmd;
    it.expire_time = exp_t;
    it.repeat_interval = per;
    it.timer_id = id;
    it.now_time = now_t;
    return it;
  endfunction

  function automatic logic [ExpW-1:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  // Driver: one nonblocking update of in_push per edge, none while a push waits on a full queue.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) predict_timer_results(cur_request);
      if (!in_push || !in_full) begin
        if (pending_requests.size() > 0 && (quiet || $urandom_range(99) >= 26)) begin
          cur_request = pending_requests.pop_front();
          in_push <= 1'b1;
          in_cmd <= cur_request.cmd;
          in_expire_time <= cur_request.expire_time;
          in_repeat_interval <= cur_request.repeat_interval;
          in_timer_id <= cur_request.timer_id;
          in_now_time <= cur_request.now_time;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = expected_results.pop_front();
          if (out_fired_valid !== e.fired_valid)
            report_mismatch($sformatf("fired_valid %b exp %b", out_fired_valid, e.fired_valid));
          if (out_fired_id !== e.fired_id)
            report_mismatch($sformatf("fired_id %0d exp %0d", out_fired_id, e.fired_id));
          if (out_last_result !== e.last_result)
            report_mismatch($sformatf("last_result %b exp %b", out_last_result, e.last_result));
          if (out_next_valid !== e.next_valid)
            report_mismatch($sformatf("next_valid %b exp %b", out_next_valid, e.next_valid));
          if (out_next_delay !== e.next_delay)
            report_mismatch($sformatf("next_delay %0d exp %0d", out_next_delay, e.next_delay));
          if (out_earliest_changed !== e.earliest_changed)
            report_mismatch($sformatf("earliest_changed %b exp %b",
                                      out_earliest_changed, e.earliest_changed));
          if (out_add_status !== e.add_status)
            report_mismatch($sformatf("add_status %0d exp %0d", out_add_status, e.add_status));
        end
      end
      out_pop <= !rx_hold && (quiet || $urandom_range(99) >= 26);
    end
  end

  task automatic write_min_delay(input logic [DlyW-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    delay_floor = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_push || expected_results.size() != 0);
    repeat (80) @(posedge clk);
  endtask

  // Random phase: mostly adds and ticks around a moving time base.
  task automatic random_phase(input int n);
    logic [ExpW-1:0] tb_now;
    logic [ExpW-1:0] ex;
    logic [PerW-1:0] per;
    tb_now = ExpW'($urandom_range(100000));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: ex = rand48();
        1: ex = tb_now - ExpW'($urandom_range(50));
        default: ex = tb_now + ExpW'($urandom_range(3000));
      endcase
      case ($urandom_range(5))
        0: per = $urandom;
        1, 2: per = '0;
        default: per = $urandom_range(1, 2000);
      endcase
      if ($urandom_range(99) < 35) begin
        tb_now = tb_now + ExpW'($urandom_range(1500));
        if ($urandom_range(29) == 0) tb_now = rand48();
        pending_requests.push_back(mk(CmdTick, rand48(), $urandom, 8'($urandom), tb_now));
      end else begin
        pending_requests.push_back(mk(CmdAdd, ex, per, 8'($urandom_range(0, 15)),
                                      $urandom_range(9) == 0 ? rand48() : tb_now));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < Depth; i++) begin
      tbl_used[i] = 1'b0;
      tbl_expiry[i] = '0;
      tbl_period[i] = '0;
      tbl_owner[i] = '0;
    end
    delay_floor = MinDelayReset;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: default floor, then the extremes of the floor.
    pending_requests.push_back(mk(CmdTick, '0, '0, '0, '0));
    pending_requests.push_back(mk(CmdAdd, 48'd1000, 32'd0, 8'd0, 48'd990));
    pending_requests.push_back(mk(CmdAdd, 48'd2000, 32'd500, 8'd255, 48'd0));
    pending_requests.push_back(mk(CmdAdd, 48'd1000, 32'd7, 8'd0, 48'd0));
    pending_requests.push_back(mk(CmdAdd, 48'd1000, 32'd300, 8'd3, 48'd0));
    pending_requests.push_back(mk(CmdAdd, 48'd500, 32'd0, 8'd9, 48'd800));
    pending_requests.push_back(mk(CmdTick, ExpMax, '1, '1, 48'd1000));
    pending_requests.push_back(mk(CmdTick, '0, '0, '0, 48'd1200));
    drain();
    write_min_delay('0);
    pending_requests.push_back(mk(CmdAdd, ExpMax, '1, 8'd77, 48'd5));
    pending_requests.push_back(mk(CmdAdd, 48'd10, '1, 8'd78, 48'd10));
    for (int i = 0; i < 15; i++)
      pending_requests.push_back(mk(CmdAdd, 48'd20 + 48'(i), 32'(i % 3), 8'(i), 48'd0));
    pending_requests.push_back(mk(CmdTick, '0, '0, '0, ExpMax - 48'd1));
    pending_requests.push_back(mk(CmdTick, '0, '0, '0, ExpMax));
    drain();
    write_min_delay('1);
    pending_requests.push_back(mk(CmdAdd, 48'd70000, 32'd0, 8'd1, 48'd0));
    pending_requests.push_back(mk(CmdTick, '0, '0, '0, 48'd80000));
    drain();

    write_min_delay(16'd100);
    quiet = 1'b1;
    random_phase(60);
    drain();
    quiet = 1'b0;
    write_min_delay(16'($urandom));
    random_phase(80);
    // The receiver holds off while requests keep arriving, so the block fills up.
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
    drain();
    write_min_delay(16'd0);
    random_phase(90);
    drain();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

endmodule
